FILE: rtl/mk_pkg.sv
package mk_pkg;

  localparam int CHAR_W = 8;
  localparam int DUR_W = 19;
  localparam int UNIT_W = 16;
  localparam int NUM_LETTERS = 26;
  localparam int LETTER_IDX_W = 5;
  localparam int CODE_LEN_W = 3;
  localparam int CODE_MAX = 4;
  localparam int POS_W = 3;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd500;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] LETTER_A = 8'd97;
  localparam logic [CHAR_W-1:0] LETTER_Z = 8'd122;

  // Segment lengths in Morse units.
  localparam logic [2:0] UNITS_DOT = 3'd1;
  localparam logic [2:0] UNITS_DASH = 3'd3;
  localparam logic [2:0] UNITS_ELEM_GAP = 3'd1;
  localparam logic [2:0] UNITS_LETTER_GAP = 3'd3;
  localparam logic [2:0] UNITS_WORD_GAP = 3'd7;

  // Number of elements in each letter, a through z.
  localparam logic [CODE_LEN_W-1:0] LETTER_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Bit i is set when element i of the letter is a dash.
  localparam logic [CODE_MAX-1:0] LETTER_DASH [NUM_LETTERS] = '{
    4'b0010, 4'b0001, 4'b0101, 4'b0001, 4'b0000, 4'b0100, 4'b0011,
    4'b0000, 4'b0000, 4'b1110, 4'b0101, 4'b0010, 4'b0011, 4'b0001,
    4'b0111, 4'b0110, 4'b1011, 4'b0010, 4'b0000, 4'b0001, 4'b0100,
    4'b1000, 4'b0110, 4'b1001, 4'b1101, 4'b0011
  };

  typedef enum logic [1:0] {
    CMD_FLUSH,
    CMD_LETTER,
    CMD_WORD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic pre_gap;
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_MAX-1:0] dash;
  } cmd_t;

endpackage

FILE: rtl/mk_char_if.sv
interface mk_char_if;
  import mk_pkg::*;

  logic valid;
  logic ready;
  logic [CHAR_W-1:0] character;
  logic end_of_text;

  modport source(output valid, output character, output end_of_text, input ready);
  modport sink(input valid, input character, input end_of_text, output ready);
endinterface

FILE: rtl/mk_seg_if.sv
interface mk_seg_if;
  import mk_pkg::*;

  logic valid;
  logic ready;
  logic lamp_on;
  logic [DUR_W-1:0] duration;
  logic last_of_run;

  modport source(output valid, output lamp_on, output duration, output last_of_run,
                 input ready);
  modport sink(input valid, input lamp_on, input duration, input last_of_run,
               output ready);
endinterface

FILE: rtl/mk_front.sv
module mk_front
  import mk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mk_char_if.sink   chars,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_data
);

  logic pending;
  logic pending_next;
  logic accept;
  logic is_letter;
  logic [LETTER_IDX_W-1:0] idx;
  logic [CHAR_W-1:0] offset;

  assign chars.ready = push_ready;
  assign accept = chars.valid && push_ready;
  assign is_letter = (chars.character >= LETTER_A) && (chars.character <= LETTER_Z);
  assign offset = chars.character - LETTER_A;
  assign idx = offset[LETTER_IDX_W-1:0];

  always_comb begin
    push_data = '0;
    pending_next = pending;
    if (chars.end_of_text) begin
      push_data.kind = CMD_FLUSH;
      push_data.pre_gap = pending;
      pending_next = 1'b0;
    end else if (is_letter) begin
      push_data.kind = CMD_LETTER;
      push_data.pre_gap = pending;
      push_data.len = LETTER_LEN[idx];
      push_data.dash = LETTER_DASH[idx];
      pending_next = 1'b1;
    end else begin
      push_data.kind = CMD_WORD;
      push_data.pre_gap = pending && (chars.character != SPACE_CHAR);
      pending_next = 1'b0;
    end
  end

  // A terminator with nothing pending leaves no work for the sequencer.
  assign push_valid = chars.valid && (!chars.end_of_text || pending);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

FILE: rtl/mk_queue.sv
module mk_queue
  import mk_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/mk_back.sv
module mk_back
  import mk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [UNIT_W-1:0] unit_ticks,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmd_t              q_data,
  mk_seg_if.source          segs
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRE,
    PH_BODY
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  cmd_t cmd;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;

  logic out_valid;
  logic out_lamp;
  logic [DUR_W-1:0] out_dur;
  logic out_last;

  logic busy;
  logic have;
  logic adv;
  logic emit;
  cmd_t cur_cmd;
  logic cur_pre;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] last_pos;
  logic [1:0] len_m1;
  logic [1:0] elem;

  logic seg_lamp;
  logic [2:0] seg_units;
  logic seg_last;
  logic [DUR_W-1:0] unit_ext;
  logic [DUR_W-1:0] seg_dur;

  assign busy = (phase != PH_IDLE);
  assign have = busy || q_valid;
  assign adv = !out_valid || segs.ready;
  assign emit = adv && have;
  assign q_ready = adv && !busy;

  assign cur_cmd = busy ? cmd : q_data;
  assign cur_pre = busy ? (phase == PH_PRE) : q_data.pre_gap;
  assign cur_pos = busy ? pos : '0;
  assign len_m1 = 2'(cur_cmd.len - 3'd1);
  assign last_pos = {len_m1, 1'b0};
  assign elem = cur_pos[2:1];

  // Elements sit at even positions, one-unit dark gaps at odd ones.
  always_comb begin
    seg_lamp = 1'b0;
    seg_units = UNITS_WORD_GAP;
    seg_last = 1'b1;
    if (cur_pre) begin
      seg_units = UNITS_LETTER_GAP;
      seg_last = (cur_cmd.kind == CMD_FLUSH);
    end else if (cur_cmd.kind == CMD_LETTER) begin
      seg_last = (cur_pos == last_pos);
      if (!cur_pos[0]) begin
        seg_lamp = 1'b1;
        seg_units = cur_cmd.dash[elem] ? UNITS_DASH : UNITS_DOT;
      end else begin
        seg_units = UNITS_ELEM_GAP;
      end
    end
  end

  // A zero unit length counts as one tick.
  assign unit_ext = (unit_ticks == '0) ? DUR_W'(1) : DUR_W'(unit_ticks);

  always_comb begin
    case (seg_units)
      UNITS_DOT:        seg_dur = unit_ext;
      UNITS_DASH:       seg_dur = (unit_ext << 1) + unit_ext;
      UNITS_WORD_GAP:   seg_dur = (unit_ext << 3) - unit_ext;
      default:          seg_dur = unit_ext;
    endcase
  end

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    if (emit) begin
      if (seg_last) begin
        phase_next = PH_IDLE;
        pos_next = '0;
      end else if (cur_pre) begin
        phase_next = PH_BODY;
        pos_next = '0;
      end else begin
        phase_next = PH_BODY;
        pos_next = cur_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      pos <= pos_next;
      if (adv) begin
        out_valid <= have;
      end
    end
    if (emit && !busy) begin
      cmd <= q_data;
    end
    if (emit) begin
      out_lamp <= seg_lamp;
      out_dur <= seg_dur;
      out_last <= seg_last;
    end
  end

  assign segs.valid = out_valid;
  assign segs.lamp_on = out_lamp;
  assign segs.duration = out_dur;
  assign segs.last_of_run = out_last;

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (phase == PH_IDLE))
    else $error("command taken while a sequence is running");

  a_no_flush_body: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (cmd.kind != CMD_FLUSH))
    else $error("flush command reached the body phase");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY && cmd.kind == CMD_LETTER) |-> (pos <= last_pos))
    else $error("element position ran past the letter");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && seg_last) |=> (phase == PH_IDLE))
    else $error("sequence kept running after its last segment");

endmodule

FILE: rtl/morse_keyer_top.sv
// Channel  | Direction | Payload                                   | Handshake
// chars    | in        | character[7:0], end_of_text               | valid/ready
// segs     | out       | lamp_on, duration[18:0], last_of_run      | valid/ready
// cfg      | in        | cfg_wr_data[15:0] -> unit_ticks           | cfg_wr_en only
//
// The back end sends one segment per cycle while it has work and the output is not stalled,
// and an item causes 1 to 8 segments, or none for a terminator with no gap pending.
// The front end classifies an item in the cycle it is accepted and needs no more.
// Reset sets unit_ticks to 500, clears the pending letter gap and empties the queue.
// Input stalls only when the command queue is full; the output register takes a new
// segment in any cycle where it is empty or its current segment is taken.
module morse_keyer_top
  import mk_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  mk_char_if.sink           chars,
  mk_seg_if.source          segs,
  input  logic              cfg_wr_en,
  input  logic [UNIT_W-1:0] cfg_wr_data
);

  // Ticks per Morse unit. Users must write it only while the block is idle; not enforced.
  logic [UNIT_W-1:0] unit_ticks;

  // Commands from the classifier to the sequencer.
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      unit_ticks <= cfg_wr_data;
    end
  end

  // The front end holds the pending letter gap and turns each character into at most one
  // command: whether a letter gap goes first, and what follows it.
  mk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front end keep taking characters while a long letter is sent.
  mk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end walks each command one segment at a time into the output register.
  mk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .unit_ticks (unit_ticks),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .segs       (segs)
  );

endmodule

FILE: dv/morse_keyer_top_tb.sv
module morse_keyer_top_tb;
  import mk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any item crossing either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles allowed after the last segment before touching the register, so
  // that the back end has surely gone idle.
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_WAIT = 18;

  typedef struct packed {
    logic             lamp_on;
    logic [DUR_W-1:0] duration;
    logic             last_of_run;
  } segment_t;

  // Expands each accepted character into the lamp segments it must cause and
  // matches them against the segments that leave the block.
  class segment_board;
    segment_t         due_q[$];
    logic [UNIT_W-1:0] unit_ticks;
    bit               gap_pending;
    int               faults;
    string            morse_tab[NUM_LETTERS];

    function new();
      unit_ticks  = UNIT_TICKS_RESET;
      gap_pending = 1'b0;
      faults      = 0;
      morse_tab   = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
    endfunction

    function void set_unit(logic [UNIT_W-1:0] value);
      unit_ticks = value;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    function void add_segment(logic lamp, logic [2:0] units);
      segment_t seg;
      int       eff;
      eff = (unit_ticks == '0) ? 1 : int'(unit_ticks);
      seg.lamp_on     = lamp;
      seg.duration    = DUR_W'(int'(units) * eff);
      seg.last_of_run = 1'b0;
      due_q.push_back(seg);
    endfunction

    function void note_char(logic [CHAR_W-1:0] ch, logic eot);
      int       base;
      int       k;
      string    pattern;
      segment_t tail;
      base = due_q.size();
      if (eot) begin
        if (gap_pending) add_segment(1'b0, UNITS_LETTER_GAP);
        gap_pending = 1'b0;
      end else if (ch >= LETTER_A && ch <= LETTER_Z) begin
        pattern = morse_tab[ch - LETTER_A];
        if (gap_pending) add_segment(1'b0, UNITS_LETTER_GAP);
        for (k = 0; k < pattern.len(); k++) begin
          if (k > 0) add_segment(1'b0, UNITS_ELEM_GAP);
          add_segment(1'b1, (pattern[k] == "-") ? UNITS_DASH : UNITS_DOT);
        end
        gap_pending = 1'b1;
      end else begin
        if (gap_pending && ch != SPACE_CHAR) add_segment(1'b0, UNITS_LETTER_GAP);
        add_segment(1'b0, UNITS_WORD_GAP);
        gap_pending = 1'b0;
      end
      if (due_q.size() > base) begin
        tail = due_q.pop_back();
        tail.last_of_run = 1'b1;
        due_q.push_back(tail);
      end
    endfunction

    function void check_seg(logic lamp, logic [DUR_W-1:0] dur, logic last);
      segment_t want;
      if (due_q.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("segment with no item waiting: lamp=%0d duration=%0d last=%0d",
                   lamp, dur, last);
        return;
      end
      want = due_q.pop_front();
      if (want.lamp_on !== lamp || want.duration !== dur || want.last_of_run !== last) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display({"segment mismatch: expected lamp=%0d duration=%0d last=%0d,",
                    " got lamp=%0d duration=%0d last=%0d"},
                   want.lamp_on, want.duration, want.last_of_run, lamp, dur, last);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [UNIT_W-1:0] cfg_wr_data;

  mk_char_if chars_if ();
  mk_seg_if  segs_if ();

  morse_keyer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .segs       (segs_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  segment_board sb = new();

  // Each side switches now and then into a calm stretch where it never idles,
  // so back-to-back traffic is covered as well as gaps on every phase.
  bit chars_calm = 1'b0;
  bit segs_calm = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Offers one character and returns right after the edge at which it was taken.
  // Valid is left high so that a following item with no wait goes out at once.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eot);
    int gap;
    gap = draw_wait(chars_calm);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.character   <= ch;
    chars_if.end_of_text <= eot;
    do @(posedge clk); while (!chars_if.ready);
    sb.note_char(ch, eot);
  endtask

  // Mostly well-formed text: letters and spaces with terminators between
  // sentences, plus some raw bytes so that every character bit toggles.
  task automatic send_random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      send_char(LETTER_A + CHAR_W'($urandom_range(0, NUM_LETTERS - 1)), 1'b0);
    else if (pick < 70)
      send_char(SPACE_CHAR, 1'b0);
    else if (pick < 80)
      send_char(CHAR_W'($urandom), 1'b1);
    else if (pick < 90)
      send_char(CHAR_W'($urandom), 1'b0);
    else
      send_char(CHAR_W'($urandom_range(33, 96)), 1'b0);
  endtask

  // Drops valid, waits until every segment has come back and the back end has
  // had time to settle, then writes unit_ticks.
  task automatic write_unit(input logic [UNIT_W-1:0] value);
    chars_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_unit(value);
  endtask

  // Segment receiver: before each segment it holds ready low for a random number of cycles, possibly none.
  initial begin
    int stall;
    segs_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(segs_calm);
      if (stall > 0) begin
        segs_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      segs_if.ready <= 1'b1;
      do @(posedge clk); while (!segs_if.valid);
      sb.check_seg(segs_if.lamp_on, segs_if.duration, segs_if.last_of_run);
    end
  end

  // Watchdog on forward progress: any accepted item on either channel resets it.
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (segs_if.valid && segs_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("morse_keyer_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [UNIT_W-1:0] unit_plan [NUM_PHASES];
    int p;
    int i;
    chars_if.valid       <= 1'b0;
    chars_if.character   <= '0;
    chars_if.end_of_text <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    rst                  <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run at the reset unit length of 500 ticks.
    // A terminator with nothing pending must cause no segment at all.
    send_char(8'd0, 1'b1);
    // A space right after a letter drops the pending letter gap.
    send_char(LETTER_A, 1'b0);
    send_char(SPACE_CHAR, 1'b0);
    send_char(SPACE_CHAR, 1'b0);
    // Any other non-letter after a letter sends the letter gap and then the word gap.
    send_char(LETTER_Z, 1'b0);
    send_char("!", 1'b0);
    // Two letters in a row: the second opens with the letter gap.
    send_char("e", 1'b0);
    send_char("e", 1'b0);
    // Uppercase, byte zero without the terminator flag, the top byte and the
    // neighbors of the letter range are all word gaps.
    send_char("A", 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(LETTER_A - 8'd1, 1'b0);
    send_char(LETTER_Z + 8'd1, 1'b0);
    // A terminator after a letter flushes the gap; its character is ignored.
    send_char("j", 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("b", 1'b1);
    // Letters with four elements and with a single one.
    send_char("q", 1'b0);
    send_char("y", 1'b0);
    send_char("h", 1'b0);
    send_char("t", 1'b0);
    send_char(8'd0, 1'b1);

    // Random part over several unit lengths: zero, which behaves as one tick,
    // the smallest and largest legal values, and a few arbitrary ones.
    unit_plan = '{16'd0, 16'd1, 16'hFFFF, UNIT_W'($urandom_range(1, 65535)), 16'd7,
                  UNIT_W'($urandom_range(1, 65535))};
    for (p = 0; p < NUM_PHASES; p++) begin
      write_unit(unit_plan[p]);
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_char();
    end

    // Drain: every segment must arrive, then give the block a few more cycles
    // to show any stray one.
    chars_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.faults == 0) begin
      $display("morse_keyer_top_tb: clean");
    end else begin
      $display("morse_keyer_top_tb: errors");
    end
    $finish;
  end

endmodule
